FILE: rtl/gnd_pkg.sv
// shared widths, codes and pipeline load enables for the gradient noise block
package gnd_pkg;

  localparam int unsigned FRAC_DEF = 16;

  localparam int unsigned TBL_AW  = 8;
  localparam int unsigned PERM_W  = 8;
  localparam int unsigned GRAD_W  = 17;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned NOISE_W = 32;
  localparam int unsigned DOT_W   = GRAD_W + 2;
  localparam int unsigned DIFF_W  = DOT_W + 1;
  localparam int unsigned MUL_W   = 2 * NOISE_W;

  // fade polynomial 6t^5 - 15t^4 + 10t^3
  localparam int unsigned FADE_C5 = 6;
  localparam int unsigned FADE_C4 = 15;
  localparam int unsigned FADE_C3 = 10;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  // one capture enable per pipeline stage, st7 is the output register
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
    logic st6;
    logic st7;
  } ld_t;

endpackage

FILE: rtl/gnd_if.sv
// request and response channel interfaces of the gradient noise block
interface gnd_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [gnd_pkg::TBL_AW-1:0]          table_index;
  logic [gnd_pkg::PERM_W-1:0]          perm_value;
  logic signed [gnd_pkg::GRAD_W-1:0]   grad_x;
  logic signed [gnd_pkg::GRAD_W-1:0]   grad_y;
  logic signed [gnd_pkg::COORD_W-1:0]  coord_x;
  logic signed [gnd_pkg::COORD_W-1:0]  coord_y;

  modport source (
    output valid, req_type, table_index, perm_value, grad_x, grad_y, coord_x, coord_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, table_index, perm_value, grad_x, grad_y, coord_x, coord_y,
    output ready
  );
endinterface

interface gnd_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [gnd_pkg::NOISE_W-1:0]  noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

FILE: rtl/gnd_ram.sv
// table memory with one write port and two registered read ports
module gnd_ram #(
  parameter int unsigned W  = gnd_pkg::PERM_W,
  parameter int unsigned AW = gnd_pkg::TBL_AW
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [W-1:0]  rdata_a_o,
  output logic [W-1:0]  rdata_b_o
);

  localparam int unsigned Depth = 1 << AW;

  logic [W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

FILE: rtl/gnd_fade.sv
// four stage pipelined quintic fade of one coordinate fraction
module gnd_fade #(
  parameter int unsigned FRAC = gnd_pkg::FRAC_DEF
) (
  input  logic                               clk_i,
  input  gnd_pkg::ld_t                       ld_i,
  input  logic [FRAC-1:0]                    t_i,
  output logic signed [gnd_pkg::NOISE_W-1:0] w_o
);

  localparam int unsigned NoiseW = gnd_pkg::NOISE_W;
  localparam int unsigned ProdW  = 2 * FRAC;

  logic [FRAC-1:0]   t1_q, t2_q;
  logic [FRAC-1:0]   t2b_q, t3_q, t4_q;
  logic [FRAC-1:0]   t3c_q, t4c_q, t5_q;
  logic [ProdW-1:0]  sq, cube, quart, quint;
  logic [NoiseW-1:0] w_d;
  logic [NoiseW-1:0] w_q;

  always_comb begin
    sq    = t_i * t_i;
    cube  = t2_q * t1_q;
    quart = t2_q * t2_q;
    quint = t3_q * t2b_q;
    w_d   = NoiseW'(t5_q) * NoiseW'(gnd_pkg::FADE_C5)
          - NoiseW'(t4c_q) * NoiseW'(gnd_pkg::FADE_C4)
          + NoiseW'(t3c_q) * NoiseW'(gnd_pkg::FADE_C3);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.st1) begin
      t1_q <= t_i;
      t2_q <= sq[ProdW-1:FRAC];
    end
    if (ld_i.st2) begin
      t2b_q <= t2_q;
      t3_q  <= cube[ProdW-1:FRAC];
      t4_q  <= quart[ProdW-1:FRAC];
    end
    if (ld_i.st3) begin
      t3c_q <= t3_q;
      t4c_q <= t4_q;
      t5_q  <= quint[ProdW-1:FRAC];
    end
    if (ld_i.st4) begin
      w_q <= w_d;
    end
  end

  assign w_o = signed'(w_q);

endmodule

FILE: rtl/gnd_blend.sv
// bilinear blend of the corner dot products, stages four through output
module gnd_blend #(
  parameter int unsigned FRAC = gnd_pkg::FRAC_DEF
) (
  input  logic                               clk_i,
  input  gnd_pkg::ld_t                       ld_i,
  input  logic signed [gnd_pkg::DOT_W-1:0]   d00_i,
  input  logic signed [gnd_pkg::DOT_W-1:0]   d10_i,
  input  logic signed [gnd_pkg::DOT_W-1:0]   d01_i,
  input  logic signed [gnd_pkg::DOT_W-1:0]   d11_i,
  input  logic signed [gnd_pkg::NOISE_W-1:0] wx_i,
  input  logic signed [gnd_pkg::NOISE_W-1:0] wy_i,
  output logic signed [gnd_pkg::NOISE_W-1:0] noise_o
);

  localparam int unsigned DotW   = gnd_pkg::DOT_W;
  localparam int unsigned DiffW  = gnd_pkg::DIFF_W;
  localparam int unsigned NoiseW = gnd_pkg::NOISE_W;
  localparam int unsigned MulW   = gnd_pkg::MUL_W;

  logic signed [DotW-1:0]   d00_q, d10_q, d01_q, d11_q;
  logic signed [DiffW-1:0]  dx0, dx1;
  logic signed [MulW-1:0]   pa, pb, pf;

  logic signed [NoiseW-1:0] ma_q, mb_q, wy5_q;
  logic signed [DotW-1:0]   d00_5_q, d01_5_q;
  logic signed [NoiseW-1:0] a5, b5;

  logic signed [NoiseW-1:0] a6_q, diff6_q, wy6_q;
  logic signed [NoiseW-1:0] noise_d, noise_q;

  always_comb begin
    dx0 = DiffW'(d10_q) - DiffW'(d00_q);
    dx1 = DiffW'(d11_q) - DiffW'(d01_q);
    pa  = wx_i * dx0;
    pb  = wx_i * dx1;
    a5  = NoiseW'(d00_5_q) + ma_q;
    b5  = NoiseW'(d01_5_q) + mb_q;
    pf  = wy6_q * diff6_q;
    noise_d = a6_q + signed'(pf[FRAC+NoiseW-1:FRAC]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.st4) begin
      d00_q <= d00_i;
      d10_q <= d10_i;
      d01_q <= d01_i;
      d11_q <= d11_i;
    end
    if (ld_i.st5) begin
      ma_q    <= signed'(pa[FRAC+NoiseW-1:FRAC]);
      mb_q    <= signed'(pb[FRAC+NoiseW-1:FRAC]);
      d00_5_q <= d00_q;
      d01_5_q <= d01_q;
      wy5_q   <= wy_i;
    end
    if (ld_i.st6) begin
      a6_q    <= a5;
      diff6_q <= b5 - a5;
      wy6_q   <= wy5_q;
    end
    if (ld_i.st7) begin
      noise_q <= noise_d;
    end
  end

  assign noise_o = noise_q;

endmodule

FILE: rtl/gradient_noise_2d_fixed.sv
// top level of the pipelined two-dimensional fixed-point gradient noise generator
//
//   port    direction  carries
//   req_i   in         table write or noise sample request
//   rsp_o   out        one noise_value per sample request
//
// seven register stages, one transaction accepted per clock when the output is free.
// a sample reaches rsp_o through stages one to six and the output register;
// table writes give no response and drop out of the pipe after stage three.
// each table copy is written at the stage where it is read, so order is kept.
// reset clears only the stage valid bits; table contents are undefined until written.
// a held response stalls the stages behind it; empty stages keep filling meanwhile.
module gradient_noise_2d_fixed #(
  parameter int unsigned FRAC = gnd_pkg::FRAC_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gnd_req_if.sink   req_i,
  gnd_rsp_if.source rsp_o
);

  localparam int unsigned AW    = gnd_pkg::TBL_AW;
  localparam int unsigned PermW = gnd_pkg::PERM_W;
  localparam int unsigned GradW = gnd_pkg::GRAD_W;
  localparam int unsigned DotW  = gnd_pkg::DOT_W;
  localparam int unsigned PrW   = GradW + FRAC + 1;

  function automatic logic signed [DotW-1:0] dot2(
    input logic signed [GradW-1:0] gx,
    input logic signed [GradW-1:0] gy,
    input logic signed [FRAC:0]    fx,
    input logic signed [FRAC:0]    fy
  );
    logic signed [PrW-1:0] qx, qy;
    logic signed [GradW:0] mx, my;
    qx = gx * fx;
    qy = gy * fy;
    mx = signed'(qx[PrW-1:FRAC]);
    my = signed'(qy[PrW-1:FRAC]);
    return DotW'(mx) + DotW'(my);
  endfunction

  gnd_pkg::ld_t ld;
  logic         v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, rsp_v_q;
  logic         acc, samp_in;

  // stage 1
  logic [AW-1:0]          s1_xi_q, s1_idx_q;
  logic [FRAC-1:0]        s1_px_q, s1_py_q;
  logic                   s1_samp_q;
  logic [PermW-1:0]       s1_perm_q;
  logic [GradW-1:0]       s1_gx_q, s1_gy_q;
  logic [AW-1:0]          y0l, y1l;
  logic [PermW-1:0]       pa0, pa1;
  logic [AW-1:0]          a00, a10, a01, a11;

  // stage 2
  logic [FRAC-1:0]        s2_px_q, s2_py_q;
  logic                   s2_samp_q;
  logic [AW-1:0]          s2_idx_q;
  logic [GradW-1:0]       s2_gx_q, s2_gy_q;
  logic [PermW-1:0]       h00, h10, h01, h11;

  // stage 3
  logic [FRAC-1:0]        s3_px_q, s3_py_q;
  logic                   s3_samp_q;
  logic [2*GradW-1:0]     g00, g10, g01, g11;
  logic signed [FRAC:0]   px0s, px1s, py0s, py1s;
  logic signed [DotW-1:0] d00, d10, d01, d11;

  logic signed [gnd_pkg::NOISE_W-1:0] wx, wy;

  // stage capture enables, a stage takes new content when empty or draining
  always_comb begin
    ld.st7 = !rsp_v_q || rsp_o.ready;
    ld.st6 = !v6_q || ld.st7;
    ld.st5 = !v5_q || ld.st6;
    ld.st4 = !v4_q || ld.st5;
    ld.st3 = !v3_q || ld.st4;
    ld.st2 = !v2_q || ld.st3;
    ld.st1 = !v1_q || ld.st2;
  end

  assign req_i.ready = ld.st1;
  assign acc         = req_i.valid && ld.st1;
  assign samp_in     = (req_i.req_type == gnd_pkg::REQ_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      if (ld.st1) v1_q <= req_i.valid;
      if (ld.st2) v2_q <= v1_q;
      if (ld.st3) v3_q <= v2_q;
      // table writes end here
      if (ld.st4) v4_q <= v3_q && s3_samp_q;
      if (ld.st5) v5_q <= v4_q;
      if (ld.st6) v6_q <= v5_q;
      if (ld.st7) rsp_v_q <= v6_q;
    end
  end

  // cell row hashes: perm[y0] and perm[y0+1]
  assign y0l = req_i.coord_y[FRAC+AW-1:FRAC];
  assign y1l = y0l + 8'd1;

  gnd_ram #(.W(PermW), .AW(AW)) u_perm_row (
    .clk_i     (clk_i),
    .we_i      (acc && !samp_in),
    .waddr_i   (req_i.table_index),
    .wdata_i   (req_i.perm_value),
    .re_i      (ld.st1),
    .raddr_a_i (y0l),
    .raddr_b_i (y1l),
    .rdata_a_o (pa0),
    .rdata_b_o (pa1)
  );

  always_ff @(posedge clk_i) begin
    if (ld.st1) begin
      s1_xi_q   <= req_i.coord_x[FRAC+AW-1:FRAC];
      s1_px_q   <= req_i.coord_x[FRAC-1:0];
      s1_py_q   <= req_i.coord_y[FRAC-1:0];
      s1_samp_q <= samp_in;
      s1_idx_q  <= req_i.table_index;
      s1_perm_q <= req_i.perm_value;
      s1_gx_q   <= req_i.grad_x;
      s1_gy_q   <= req_i.grad_y;
    end
  end

  // corner hashes
  always_comb begin
    a00 = s1_xi_q + pa0;
    a10 = s1_xi_q + 8'd1 + pa0;
    a01 = s1_xi_q + pa1;
    a11 = s1_xi_q + 8'd1 + pa1;
  end

  gnd_ram #(.W(PermW), .AW(AW)) u_perm_lo (
    .clk_i     (clk_i),
    .we_i      (v1_q && !s1_samp_q && ld.st2),
    .waddr_i   (s1_idx_q),
    .wdata_i   (s1_perm_q),
    .re_i      (ld.st2),
    .raddr_a_i (a00),
    .raddr_b_i (a10),
    .rdata_a_o (h00),
    .rdata_b_o (h10)
  );

  gnd_ram #(.W(PermW), .AW(AW)) u_perm_hi (
    .clk_i     (clk_i),
    .we_i      (v1_q && !s1_samp_q && ld.st2),
    .waddr_i   (s1_idx_q),
    .wdata_i   (s1_perm_q),
    .re_i      (ld.st2),
    .raddr_a_i (a01),
    .raddr_b_i (a11),
    .rdata_a_o (h01),
    .rdata_b_o (h11)
  );

  always_ff @(posedge clk_i) begin
    if (ld.st2) begin
      s2_px_q   <= s1_px_q;
      s2_py_q   <= s1_py_q;
      s2_samp_q <= s1_samp_q;
      s2_idx_q  <= s1_idx_q;
      s2_gx_q   <= s1_gx_q;
      s2_gy_q   <= s1_gy_q;
    end
  end

  // gradient lookup, x and y components packed side by side
  gnd_ram #(.W(2 * GradW), .AW(AW)) u_grad_lo (
    .clk_i     (clk_i),
    .we_i      (v2_q && !s2_samp_q && ld.st3),
    .waddr_i   (s2_idx_q),
    .wdata_i   ({s2_gx_q, s2_gy_q}),
    .re_i      (ld.st3),
    .raddr_a_i (h00),
    .raddr_b_i (h10),
    .rdata_a_o (g00),
    .rdata_b_o (g10)
  );

  gnd_ram #(.W(2 * GradW), .AW(AW)) u_grad_hi (
    .clk_i     (clk_i),
    .we_i      (v2_q && !s2_samp_q && ld.st3),
    .waddr_i   (s2_idx_q),
    .wdata_i   ({s2_gx_q, s2_gy_q}),
    .re_i      (ld.st3),
    .raddr_a_i (h01),
    .raddr_b_i (h11),
    .rdata_a_o (g01),
    .rdata_b_o (g11)
  );

  always_ff @(posedge clk_i) begin
    if (ld.st3) begin
      s3_px_q   <= s2_px_q;
      s3_py_q   <= s2_py_q;
      s3_samp_q <= s2_samp_q;
    end
  end

  // far corner offset is the fraction minus one, i.e. the same bits with a set sign
  always_comb begin
    px0s = signed'({1'b0, s3_px_q});
    px1s = signed'({1'b1, s3_px_q});
    py0s = signed'({1'b0, s3_py_q});
    py1s = signed'({1'b1, s3_py_q});
    d00  = dot2(g00[2*GradW-1:GradW], g00[GradW-1:0], px0s, py0s);
    d10  = dot2(g10[2*GradW-1:GradW], g10[GradW-1:0], px1s, py0s);
    d01  = dot2(g01[2*GradW-1:GradW], g01[GradW-1:0], px0s, py1s);
    d11  = dot2(g11[2*GradW-1:GradW], g11[GradW-1:0], px1s, py1s);
  end

  gnd_fade #(.FRAC(FRAC)) u_fade_x (
    .clk_i (clk_i),
    .ld_i  (ld),
    .t_i   (req_i.coord_x[FRAC-1:0]),
    .w_o   (wx)
  );

  gnd_fade #(.FRAC(FRAC)) u_fade_y (
    .clk_i (clk_i),
    .ld_i  (ld),
    .t_i   (req_i.coord_y[FRAC-1:0]),
    .w_o   (wy)
  );

  gnd_blend #(.FRAC(FRAC)) u_blend (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .d00_i   (d00),
    .d10_i   (d10),
    .d01_i   (d01),
    .d11_i   (d11),
    .wx_i    (wx),
    .wy_i    (wy),
    .noise_o (rsp_o.noise_value)
  );

  assign rsp_o.valid = rsp_v_q;

  // input only backs up when every stage is full and the response is held
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q && rsp_v_q
                      && !rsp_o.ready))
    else $error("input stalled with a free stage");

  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && ld.st7) |=> rsp_o.valid)
    else $error("sample lost between stage six and output");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !ld.st7) |=> v6_q)
    else $error("stage six dropped while output held");

  a_write_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !s3_samp_q && ld.st4) |=> !v4_q)
    else $error("table write passed into blend stages");

endmodule
